// File: rtl/core/tdsr_pkg.sv
// ----------------------------------------------------------------------------
// tdsr_pkg
// shared codes, types and the device state mapping of the transfer slot ring
// ----------------------------------------------------------------------------
`default_nettype none

package tdsr_pkg;

  // item kinds
  localparam logic [1:0] MODE_CLAIM  = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_REAP   = 2'd2;

  // internal slot state codes, bit 2 marks a completed transfer
  localparam logic [2:0] ST_FREE      = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_ACTIVE    = 3'd2;
  localparam logic [2:0] ST_SUCCESS   = 3'd4;
  localparam logic [2:0] ST_ERROR     = 3'd5;
  localparam logic [2:0] ST_CANCELLED = 3'd6;
  localparam logic [2:0] ST_INVALID   = 3'd7;

  // state codes as the device reports them
  localparam logic [2:0] NS_PENDING   = 3'd0;
  localparam logic [2:0] NS_ACTIVE    = 3'd1;
  localparam logic [2:0] NS_SUCCESS   = 3'd2;
  localparam logic [2:0] NS_ERROR     = 3'd3;
  localparam logic [2:0] NS_CANCELLED = 3'd4;

  // reap status
  localparam logic [1:0] STAT_SUCCESS = 2'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alen;
    logic        revert;
  } reap_res_t;

  function automatic logic [2:0] map_new_state(input logic [2:0] ns);
    logic [2:0] st;
    case (ns)
      NS_PENDING:   st = ST_PENDING;
      NS_ACTIVE:    st = ST_ACTIVE;
      NS_SUCCESS:   st = ST_SUCCESS;
      NS_ERROR:     st = ST_ERROR;
      NS_CANCELLED: st = ST_CANCELLED;
      default:      st = ST_INVALID;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tdsr_reap_eval.sv
// ----------------------------------------------------------------------------
// tdsr_reap_eval
// status, actual length and toggle revert of a completed slot
// ----------------------------------------------------------------------------
`default_nettype none

module tdsr_reap_eval (
  input  wire logic [2:0]          st,
  input  wire logic [15:0]         length,
  input  wire logic [15:0]         remaining,
  input  wire logic                has_data,
  output tdsr_pkg::reap_res_t      res
);
  import tdsr_pkg::*;

  logic [1:0] code;
  logic       use_len;

  assign code    = 2'(st - ST_SUCCESS);
  // remaining beyond length saturates to zero
  assign use_len = (st == ST_SUCCESS) && has_data && (length >= remaining);

  always_comb begin
    res.status = code;
    res.alen   = use_len ? (length - remaining) : 16'd0;
    res.revert = (code != STAT_SUCCESS);
  end

endmodule

`default_nettype wire

// File: rtl/core/transfer_descriptor_slot_ring.sv
// ----------------------------------------------------------------------------
// transfer_descriptor_slot_ring
// update and unknown beats go straight to S_DONE and give a result when the
// output register is free; claim and reap walk the state table one slot per
// cycle on its read port; one item at a time, in_ready low meanwhile
// reset: synchronous rst_n, then a clearing pass frees every slot
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_descriptor_slot_ring #(
  parameter int SLOTS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [6:0]  in_device_addr,
  input  wire logic [3:0]  in_endpoint,
  input  wire logic [1:0]  in_speed,
  input  wire logic [6:0]  in_hub_addr,
  input  wire logic [6:0]  in_hub_port,
  input  wire logic        in_data_toggle,
  input  wire logic        in_has_setup,
  input  wire logic        in_has_data,
  input  wire logic [15:0] in_byte_count,
  input  wire logic [6:0]  in_slot_index,
  input  wire logic [2:0]  in_new_state,
  // result beats
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_ok,
  output      logic [6:0]  out_slot,
  output      logic [30:0] out_endpoint_word,
  output      logic [1:0]  out_transaction_count,
  output      logic [1:0]  out_status_code,
  output      logic [15:0] out_xfer_length,
  output      logic        out_toggle_revert
);
  import tdsr_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } fsm_t;

  // one result beat
  typedef struct packed {
    logic        ok;
    logic [6:0]  slot;
    logic [30:0] ep_word;
    logic [1:0]  tcnt;
    logic [1:0]  status;
    logic [15:0] alen;
    logic        revert;
  } res_t;

  // slot table, one entry per slot
  logic [2:0]  state_mem [SLOTS];
  logic [15:0] len_mem   [SLOTS];
  logic        hd_mem    [SLOTS];
  logic [15:0] rem_mem   [SLOTS];

  fsm_t          state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] claim_ptr_r, claim_ptr_nxt;
  logic [IW-1:0] reap_ptr_r, reap_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] issue_cnt_r, issue_cnt_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // captured item fields
  logic [1:0]  mode_r, mode_nxt;
  logic [30:0] ep_word_r, ep_word_nxt;
  logic [1:0]  tcnt_r, tcnt_nxt;
  logic [15:0] cap_len_r, cap_len_nxt;
  logic        cap_hd_r, cap_hd_nxt;
  res_t        res_r, res_nxt;
  res_t        out_r, out_nxt;

  // registered table reads at rd_ptr_r
  logic [2:0]  rd_state_r;
  logic [15:0] rd_len_r;
  logic        rd_hd_r;
  logic [15:0] rd_rem_r;

  // table write controls
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [2:0]    st_wdata;
  logic          ld_we;
  logic          rem_we;
  logic [IW-1:0] upd_addr;

  logic [IW-1:0] rd_next, chk_next;
  logic          upd_in_range;
  logic          scan_hit, scan_end;
  reap_res_t     reap_res;

  assign rd_next  = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
  assign chk_next = (chk_idx_r == LAST) ? '0 : chk_idx_r + 1'b1;

  assign upd_addr     = IW'(in_slot_index);
  assign upd_in_range = (32'(in_slot_index) < 32'(SLOTS));

  // shared compare: free slot for a claim, completed slot for a reap
  assign scan_hit = chk_vld_r &&
                    ((mode_r == MODE_CLAIM) ? (rd_state_r == ST_FREE) : rd_state_r[2]);
  // every slot issued and the last one checked
  assign scan_end = !chk_vld_r && (issue_cnt_r == FULL);

  tdsr_reap_eval u_reap_eval (
    .st        (rd_state_r),
    .length    (rd_len_r),
    .remaining (rd_rem_r),
    .has_data  (rd_hd_r),
    .res       (reap_res)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    claim_ptr_nxt = claim_ptr_r;
    reap_ptr_nxt  = reap_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    issue_cnt_nxt = issue_cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    mode_nxt      = mode_r;
    ep_word_nxt   = ep_word_r;
    tcnt_nxt      = tcnt_r;
    cap_len_nxt   = cap_len_r;
    cap_hd_nxt    = cap_hd_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    st_we         = 1'b0;
    st_waddr      = chk_idx_r;
    st_wdata      = ST_FREE;
    ld_we         = 1'b0;
    rem_we        = 1'b0;

    // result beat taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // clearing pass, one slot per cycle
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = ST_FREE;
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_mode;
          ep_word_nxt = {ST_PENDING, in_data_toggle, in_speed, in_endpoint,
                         in_hub_port, in_hub_addr, in_device_addr};
          tcnt_nxt    = {1'b0, in_has_setup} + {1'b0, in_has_data};
          cap_len_nxt = in_byte_count;
          cap_hd_nxt  = in_has_data;
          res_nxt     = '0;
          case (in_mode)
            MODE_CLAIM, MODE_REAP: begin
              rd_ptr_nxt    = (in_mode == MODE_CLAIM) ? claim_ptr_r : reap_ptr_r;
              issue_cnt_nxt = '0;
              chk_vld_nxt   = 1'b0;
              state_nxt     = S_SCAN;
            end
            MODE_UPDATE: begin
              // out of range slot index leaves the table alone
              if (upd_in_range) begin
                st_we    = 1'b1;
                st_waddr = upd_addr;
                st_wdata = map_new_state(in_new_state);
                rem_we   = 1'b1;
              end
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read issue, one slot per cycle around the ring
        if (issue_cnt_r != FULL) begin
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = rd_ptr_r;
          rd_ptr_nxt    = rd_next;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (scan_hit) begin
          st_we       = 1'b1;
          st_waddr    = chk_idx_r;
          res_nxt.ok   = 1'b1;
          res_nxt.slot = 7'(chk_idx_r);
          if (mode_r == MODE_CLAIM) begin
            // claim pointer stays on the claimed slot
            st_wdata        = ST_PENDING;
            ld_we           = 1'b1;
            claim_ptr_nxt   = chk_idx_r;
            res_nxt.ep_word = ep_word_r;
            res_nxt.tcnt    = tcnt_r;
          end else begin
            // reap pointer moves past the reaped slot, slot is freed
            st_wdata       = ST_FREE;
            reap_ptr_nxt   = chk_next;
            res_nxt.status = reap_res.status;
            res_nxt.alen   = reap_res.alen;
            res_nxt.revert = reap_res.revert;
          end
          state_nxt = S_DONE;
        end else if (scan_end) begin
          // full circle with no match, pointer back at its start
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      claim_ptr_r <= '0;
      reap_ptr_r  <= '0;
      rd_ptr_r    <= '0;
      issue_cnt_r <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      mode_r      <= MODE_CLAIM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      claim_ptr_r <= claim_ptr_nxt;
      reap_ptr_r  <= reap_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ep_word_r <= ep_word_nxt;
    tcnt_r    <= tcnt_nxt;
    cap_len_r <= cap_len_nxt;
    cap_hd_r  <= cap_hd_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // slot table: one write port per array, registered read at rd_ptr_r
  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[st_waddr] <= st_wdata;
    end
    if (ld_we) begin
      len_mem[chk_idx_r] <= cap_len_r;
      hd_mem[chk_idx_r]  <= cap_hd_r;
    end
    if (rem_we) begin
      rem_mem[upd_addr] <= in_byte_count;
    end
    rd_state_r <= state_mem[rd_ptr_r];
    rd_len_r   <= len_mem[rd_ptr_r];
    rd_hd_r    <= hd_mem[rd_ptr_r];
    rd_rem_r   <= rem_mem[rd_ptr_r];
  end

  assign out_valid             = out_valid_r;
  assign out_ok                = out_r.ok;
  assign out_slot              = out_r.slot;
  assign out_endpoint_word     = out_r.ep_word;
  assign out_transaction_count = out_r.tcnt;
  assign out_status_code       = out_r.status;
  assign out_xfer_length       = out_r.alen;
  assign out_toggle_revert     = out_r.revert;

  // checks
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(issue_cnt_r) <= 32'(SLOTS)))
    else $error("scan issued more reads than slots");

  a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (32'(chk_idx_r) < 32'(SLOTS)))
    else $error("checked slot index out of range");

  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_hit) |=> (state_r == S_DONE))
    else $error("scan hit did not finish the item");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=>
      (state_r == S_DONE && out_valid_r))
    else $error("result overwrote a beat not yet taken");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_ready && !out_valid_r))
    else $error("traffic during clearing pass");

endmodule

`default_nettype wire
